### rtl/d2q9_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_pkg: shared types, constants and helpers for the D2Q9 BGK collision
// Stage numbering, lattice weights, the divider step and saturation.
// ----------------------------------------------------------------------------
package d2q9_pkg;

   localparam int DIRS      = 9;
   localparam int DIV_STEPS = 32;

   // Pipeline stage numbers (register stage that holds the named result).
   localparam int S_IN   = 1;
   localparam int S_SUM  = 2;
   localparam int S_PREP = 3;
   localparam int S_USAT = S_PREP + DIV_STEPS + 1;
   localparam int S_SCL  = S_USAT + 1;
   localparam int S_USC  = S_SCL + 1;
   localparam int S_SQ   = S_USC + 1;
   localparam int S_T    = S_SQ + 1;
   localparam int S_TT   = S_T + 1;
   localparam int S_POLY = S_TT + 1;
   localparam int S_FEQP = S_POLY + 1;
   localparam int S_DIFF = S_FEQP + 1;
   localparam int S_OMP  = S_DIFF + 1;
   localparam int S_OUT  = S_OMP + 1;

   localparam logic [12:0] GRID_MAX = 13'd4096;

   localparam logic [1:0] REG_OMEGA  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [29:0] OMEGA_RESET = 30'd268435456;
   localparam logic [12:0] SIZE_RESET  = 13'd64;

   localparam logic signed [39:0] Q_ONE = 40'sd268435456;

   // Lattice weights 4/9, 1/9 and 1/36 in Q4.28.
   localparam logic [26:0] W_TAB [DIRS] = '{
      27'd119304647, 27'd29826162, 27'd29826162, 27'd29826162, 27'd29826162,
      27'd7456540, 27'd7456540, 27'd7456540, 27'd7456540 };

   typedef struct packed {
      logic [DIRS-1:0][31:0] f;
      logic signed [35:0]    rho;
      logic [28:0]           scale;
      logic                  pass;
      logic                  bad;
   } carry_type;

   typedef struct packed {
      logic        neg;
      logic        ov;
      logic [34:0] rem;
      logic [31:0] lo;
      logic [31:0] quo;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // One restoring step: brings down the next dividend bit.
   function automatic div_type div_step(input div_type a, input logic [34:0] d);
      logic [35:0] rs;
      div_type     b;
      b    = a;
      rs   = {a.rem, a.lo[31]};
      b.lo = {a.lo[30:0], 1'b0};
      if (rs >= {1'b0, d}) begin
         b.rem = 35'(rs - {1'b0, d});
         b.quo = {a.quo[30:0], 1'b1};
      end else begin
         b.rem = rs[34:0];
         b.quo = {a.quo[30:0], 1'b0};
      end
      return b;
   endfunction

   // Signed, saturated quotient from a finished division.
   function automatic logic signed [31:0] u_sat(input div_type a);
      logic signed [31:0] r;
      if (a.ov || a.quo[31]) begin
         r = a.neg ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         r = a.neg ? -$signed(a.quo) : $signed(a.quo);
      end
      return r;
   endfunction

   // cx*ux + cy*uy for direction d.
   function automatic logic signed [33:0] dir_dot(input int d,
                                                  input logic signed [31:0] ux,
                                                  input logic signed [31:0] uy);
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] r;
      x = {{2{ux[31]}}, ux};
      y = {{2{uy[31]}}, uy};
      unique case (d)
         1:       r = x;
         2:       r = y;
         3:       r = -x;
         4:       r = -y;
         5:       r = x + y;
         6:       r = y - x;
         7:       r = -x - y;
         8:       r = x - y;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/d2q9_bgk_collision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_bgk_collision: D2Q9 BGK collision for one lattice node per clock unless stalled
// Density, momentum, velocity by pipelined division, second-order
// equilibrium and relaxation by omega, in saturating Q4.28 fixed point.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  nine pdfs, scale, node_x, node_y
//  rsp_      out        rsp_valid/rsp_stall  nine new pdfs, density_bad
//  csr_      in/out     APB-style, pready=1  omega, grid_width, grid_height
//
// One item enters per clock unless a stalled result holds the pipeline, and its
// result is presented from the 46th register stage; the pipeline length is
// set by the 32-stage restoring divider that forms the velocity.
// Reset is synchronous and clears the valid bits and loads the register
// defaults (omega 1.0, a 64 by 64 grid). A stall on the result channel
// freezes the whole pipeline, so the input is stalled in the same cycle;
// while the output stage is empty the pipeline keeps moving regardless.
//
module d2q9_bgk_collision
   import d2q9_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_pdf_rest,
   input  wire logic [31:0] req_pdf_east,
   input  wire logic [31:0] req_pdf_north,
   input  wire logic [31:0] req_pdf_west,
   input  wire logic [31:0] req_pdf_south,
   input  wire logic [31:0] req_pdf_northeast,
   input  wire logic [31:0] req_pdf_northwest,
   input  wire logic [31:0] req_pdf_southwest,
   input  wire logic [31:0] req_pdf_southeast,
   input  wire logic [28:0] req_scale,
   input  wire logic [11:0] req_node_x,
   input  wire logic [11:0] req_node_y,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_out_rest,
   output      logic [31:0] rsp_out_east,
   output      logic [31:0] rsp_out_north,
   output      logic [31:0] rsp_out_west,
   output      logic [31:0] rsp_out_south,
   output      logic [31:0] rsp_out_northeast,
   output      logic [31:0] rsp_out_northwest,
   output      logic [31:0] rsp_out_southwest,
   output      logic [31:0] rsp_out_southeast,
   output      logic        rsp_density_bad,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // ---------------------------------------------------------------- config
   logic [29:0] omega_ff;
   logic [12:0] grid_width_ff;
   logic [12:0] grid_height_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff       <= OMEGA_RESET;
         grid_width_ff  <= SIZE_RESET;
         grid_height_ff <= SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_OMEGA:  omega_ff       <= csr_pwdata[29:0];
            REG_WIDTH:  grid_width_ff  <= csr_pwdata[12:0];
            REG_HEIGHT: grid_height_ff <= csr_pwdata[12:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_OMEGA:  csr_prdata = {2'b0, omega_ff};
         REG_WIDTH:  csr_prdata = {19'b0, grid_width_ff};
         REG_HEIGHT: csr_prdata = {19'b0, grid_height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // --------------------------------------------------------- flow control
   // Every stage advances together; only a held result stops the pipe.
   logic [S_OUT:1] vld_ff;
   logic           en;

   assign en        = !vld_ff[S_OUT] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[S_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[S_OUT-1:1], req_valid};
      end
   end

   // ------------------------------------------------------ stage 1: capture
   // Edge detection uses the far-edge test x + 1 == width, so that a width
   // of zero never matches.
   carry_type   cry_ff [1:S_OMP];
   carry_type   c1_in;
   carry_type   c2_in;
   carry_type   c3_in;
   logic [12:0] gw_clip;
   logic [12:0] gh_clip;
   logic [12:0] xp1;
   logic [12:0] yp1;

   always_comb begin
      gw_clip = (grid_width_ff > GRID_MAX) ? GRID_MAX : grid_width_ff;
      gh_clip = (grid_height_ff > GRID_MAX) ? GRID_MAX : grid_height_ff;
      xp1     = {1'b0, req_node_x} + 13'd1;
      yp1     = {1'b0, req_node_y} + 13'd1;
      c1_in.f[0]  = req_pdf_rest;
      c1_in.f[1]  = req_pdf_east;
      c1_in.f[2]  = req_pdf_north;
      c1_in.f[3]  = req_pdf_west;
      c1_in.f[4]  = req_pdf_south;
      c1_in.f[5]  = req_pdf_northeast;
      c1_in.f[6]  = req_pdf_northwest;
      c1_in.f[7]  = req_pdf_southwest;
      c1_in.f[8]  = req_pdf_southeast;
      c1_in.rho   = '0;
      c1_in.scale = req_scale;
      c1_in.bad   = 1'b0;
      c1_in.pass  = (req_node_x == 12'd0) || (req_node_y == 12'd0) ||
                    (xp1 == gw_clip) || (yp1 == gh_clip);
   end

   // ---------------------------------------------------- stage 2: moments
   logic signed [35:0] fs [DIRS];
   logic signed [35:0] jx_in;
   logic signed [35:0] jy_in;
   logic signed [35:0] jx_ff;
   logic signed [35:0] jy_ff;

   always_comb begin
      for (int d = 0; d < DIRS; d++) begin
         fs[d] = {{4{cry_ff[S_IN].f[d][31]}}, cry_ff[S_IN].f[d]};
      end
      c2_in     = cry_ff[S_IN];
      c2_in.rho = fs[0] + fs[1] + fs[2] + fs[3] + fs[4] + fs[5] + fs[6] + fs[7] + fs[8];
      jx_in     = fs[1] - fs[3] + fs[5] - fs[6] - fs[7] + fs[8];
      jy_in     = fs[2] - fs[4] + fs[5] + fs[6] - fs[7] - fs[8];
   end

   // ------------------------------------------ stage 3: divider set-up
   // The quotient |j| * 2^28 / rho overflows 32 bits exactly when
   // |j| >= 16 * rho; otherwise the top part of the dividend is already
   // below the divisor and 32 restoring steps give the quotient.
   div_type     div_ff [0:DIV_STEPS][2];
   div_type     div_in [0:DIV_STEPS][2];
   logic [35:0] ax [2];
   logic        jneg [2];

   always_comb begin
      c3_in      = cry_ff[S_SUM];
      c3_in.bad  = !cry_ff[S_SUM].pass &&
                   (cry_ff[S_SUM].rho[35] || (cry_ff[S_SUM].rho == '0));
      c3_in.pass = cry_ff[S_SUM].pass || c3_in.bad;
      jneg[0] = jx_ff[35];
      jneg[1] = jy_ff[35];
      ax[0]   = jx_ff[35] ? 36'(-jx_ff) : 36'(jx_ff);
      ax[1]   = jy_ff[35] ? 36'(-jy_ff) : 36'(jy_ff);
      for (int i = 0; i < 2; i++) begin
         div_in[0][i].neg = jneg[i];
         div_in[0][i].ov  = {3'b0, ax[i]} >= {cry_ff[S_SUM].rho[34:0], 4'b0};
         div_in[0][i].rem = div_in[0][i].ov ? 35'd0 : {3'b0, ax[i][35:4]};
         div_in[0][i].lo  = {ax[i][3:0], 28'b0};
         div_in[0][i].quo = '0;
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         for (int i = 0; i < 2; i++) begin
            div_in[k][i] = div_step(div_ff[k-1][i], cry_ff[S_PREP+k-1].rho[34:0]);
         end
      end
   end

   // ------------------------------------------------- velocity stages
   logic signed [31:0] u_in [2];
   logic signed [31:0] u_ff [2];
   logic signed [29:0] sc_s;
   logic signed [61:0] pu_in [2];
   logic signed [61:0] pu_ff [2];
   logic signed [31:0] us_in [2];
   logic signed [31:0] us_ff [2];
   logic signed [63:0] uu_in [2];
   logic signed [63:0] uu_ff [2];
   logic signed [31:0] us2_ff [2];

   always_comb begin
      sc_s = $signed({1'b0, cry_ff[S_USAT].scale});
      for (int i = 0; i < 2; i++) begin
         u_in[i]  = u_sat(div_ff[DIV_STEPS][i]);
         pu_in[i] = u_ff[i] * sc_s;
         us_in[i] = sat32({{6{pu_ff[i][61]}}, pu_ff[i][61:28]});
         uu_in[i] = us_ff[i] * us_ff[i];
      end
   end

   // ------------------------------------------------ equilibrium stages
   logic [35:0]        sq0;
   logic [35:0]        sq1;
   logic [36:0]        sqs;
   logic [37:0]        sq3;
   logic [36:0]        usq_in;
   logic [36:0]        usq_ff;
   logic [36:0]        usq2_ff;
   logic signed [33:0] dot [DIRS];
   logic signed [35:0] dot3 [DIRS];
   logic signed [31:0] t_in [DIRS];
   logic signed [31:0] t_ff [DIRS];
   logic signed [31:0] t2_ff [DIRS];
   logic signed [63:0] rwp_in [DIRS];
   logic signed [63:0] rwp_ff [DIRS];
   logic signed [63:0] tt_in [DIRS];
   logic signed [63:0] tt_ff [DIRS];
   logic signed [31:0] rw_in [DIRS];
   logic signed [31:0] rw_ff [DIRS];
   logic signed [31:0] rw2_ff [DIRS];
   logic signed [39:0] pl [DIRS];
   logic signed [31:0] poly_in [DIRS];
   logic signed [31:0] poly_ff [DIRS];
   logic signed [63:0] feqp_in [DIRS];
   logic signed [63:0] feqp_ff [DIRS];
   logic signed [31:0] feq [DIRS];
   logic signed [32:0] diff_in [DIRS];
   logic signed [32:0] diff_ff [DIRS];
   logic signed [30:0] om_s;
   logic signed [63:0] op_in [DIRS];
   logic signed [63:0] op_ff [DIRS];
   logic signed [36:0] osum [DIRS];
   logic [31:0]        out_in [DIRS];
   logic [31:0]        out_ff [DIRS];

   always_comb begin
      // Squares are never negative, so their floors are plain part-selects.
      sq0    = uu_ff[0][63:28];
      sq1    = uu_ff[1][63:28];
      sqs    = {1'b0, sq0} + {1'b0, sq1};
      sq3    = {sqs, 1'b0} + {1'b0, sqs};
      usq_in = sq3[37:1];
      om_s   = $signed({1'b0, omega_ff});
      for (int d = 0; d < DIRS; d++) begin
         dot[d]     = dir_dot(d, us2_ff[0], us2_ff[1]);
         dot3[d]    = {dot[d][33], dot[d], 1'b0} + {{2{dot[d][33]}}, dot[d]};
         t_in[d]    = sat32({{4{dot3[d][35]}}, dot3[d]});
         rwp_in[d]  = cry_ff[S_SQ].rho * $signed({1'b0, W_TAB[d]});
         tt_in[d]   = t_ff[d] * t_ff[d];
         rw_in[d]   = sat32({{4{rwp_ff[d][63]}}, rwp_ff[d][63:28]});
         pl[d]      = Q_ONE + {{8{t2_ff[d][31]}}, t2_ff[d]} +
                      $signed({5'b0, tt_ff[d][63:29]}) - $signed({3'b0, usq2_ff});
         poly_in[d] = sat32(pl[d]);
         feqp_in[d] = rw2_ff[d] * poly_ff[d];
         feq[d]     = sat32({{4{feqp_ff[d][63]}}, feqp_ff[d][63:28]});
         diff_in[d] = {feq[d][31], feq[d]} -
                      {cry_ff[S_FEQP].f[d][31], cry_ff[S_FEQP].f[d]};
         op_in[d]   = om_s * diff_ff[d];
         osum[d]    = {{5{cry_ff[S_OMP].f[d][31]}}, cry_ff[S_OMP].f[d]} +
                      {op_ff[d][63], op_ff[d][63:28]};
         // Edge nodes and nodes without a positive density keep their inputs.
         out_in[d]  = cry_ff[S_OMP].pass ? cry_ff[S_OMP].f[d]
                                         : sat32({{3{osum[d][36]}}, osum[d]});
      end
   end

   // -------------------------------------------------- payload registers
   logic bad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cry_ff[S_IN]   <= c1_in;
         cry_ff[S_SUM]  <= c2_in;
         cry_ff[S_PREP] <= c3_in;
         for (int k = S_PREP + 1; k <= S_OMP; k++) begin
            cry_ff[k] <= cry_ff[k-1];
         end
         jx_ff <= jx_in;
         jy_ff <= jy_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            for (int i = 0; i < 2; i++) begin
               div_ff[k][i] <= div_in[k][i];
            end
         end
         for (int i = 0; i < 2; i++) begin
            u_ff[i]   <= u_in[i];
            pu_ff[i]  <= pu_in[i];
            us_ff[i]  <= us_in[i];
            uu_ff[i]  <= uu_in[i];
            us2_ff[i] <= us_ff[i];
         end
         usq_ff  <= usq_in;
         usq2_ff <= usq_ff;
         for (int d = 0; d < DIRS; d++) begin
            t_ff[d]    <= t_in[d];
            rwp_ff[d]  <= rwp_in[d];
            tt_ff[d]   <= tt_in[d];
            t2_ff[d]   <= t_ff[d];
            rw_ff[d]   <= rw_in[d];
            rw2_ff[d]  <= rw_ff[d];
            poly_ff[d] <= poly_in[d];
            feqp_ff[d] <= feqp_in[d];
            diff_ff[d] <= diff_in[d];
            op_ff[d]   <= op_in[d];
            out_ff[d]  <= out_in[d];
         end
         bad_ff <= cry_ff[S_OMP].bad;
      end
   end

   assign rsp_out_rest      = out_ff[0];
   assign rsp_out_east      = out_ff[1];
   assign rsp_out_north     = out_ff[2];
   assign rsp_out_west      = out_ff[3];
   assign rsp_out_south     = out_ff[4];
   assign rsp_out_northeast = out_ff[5];
   assign rsp_out_northwest = out_ff[6];
   assign rsp_out_southwest = out_ff[7];
   assign rsp_out_southeast = out_ff[8];
   assign rsp_density_bad   = bad_ff;

endmodule
`default_nettype wire
